// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// next-cycle implication, also checked while reset is high
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/rit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_pkg
// Types, constants and helper functions for the radix integer to text block.
// ----------------------------------------------------------------------------
package rit_pkg;

   localparam int MAX_SYMBOLS     = 16;
   localparam int NUMBER_WIDTH    = 32;
   localparam int DIGIT_SLOTS     = NUMBER_WIDTH + 1;
   localparam int DIGIT_BITS      = $clog2(MAX_SYMBOLS);
   localparam int COUNT_BITS      = $clog2(DIGIT_SLOTS + 1);
   localparam int STEPS_PER_CYCLE = 8;
   localparam int DIV_CYCLES      = (NUMBER_WIDTH + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
   localparam int DIV_WIDTH       = DIV_CYCLES * STEPS_PER_CYCLE;
   localparam int DIV_CNT_BITS    = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int IN_WIDTH        = 32;
   localparam int CHAR_BITS       = 8;
   localparam int RADIX_BITS      = 5;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int SYMBOLS_WIDTH   = 2 * CSR_DATA_BITS;

   localparam logic [CHAR_BITS-1:0] SIGN_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] SIGN_MINUS = 8'h2D;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASE_LENGTH  = 2'd0,
      CSR_SYMBOLS_LOW  = 2'd1,
      CSR_SYMBOLS_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_SIGN,
      BACK_EMIT
   } back_state_type;

   typedef struct packed {
      logic                    negative;
      logic [NUMBER_WIDTH-1:0] magnitude;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic                     base_ok;
      logic [RADIX_BITS-1:0]    radix;
      logic [SYMBOLS_WIDTH-1:0] symbols;
   } cfg_type;

   function automatic logic base_valid(input logic [RADIX_BITS-1:0]    n,
                                       input logic [SYMBOLS_WIDTH-1:0] syms);
      logic                 ok;
      logic [CHAR_BITS-1:0] sa;
      ok = (int'(n) >= 2) && (int'(n) <= MAX_SYMBOLS);
      for (int a = 0; a < MAX_SYMBOLS; a++) begin
         sa = syms[CHAR_BITS*a +: CHAR_BITS];
         if (a < int'(n)) begin
            if (sa == '0 || sa == SIGN_PLUS || sa == SIGN_MINUS) begin
               ok = 1'b0;
            end
            for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
               if (b < int'(n) && syms[CHAR_BITS*b +: CHAR_BITS] == sa) begin
                  ok = 1'b0;
               end
            end
         end
      end
      return ok;
   endfunction

   function automatic logic [CHAR_BITS-1:0] symbol_at(input logic [DIGIT_BITS-1:0]    digit,
                                                      input logic [SYMBOLS_WIDTH-1:0] syms);
      return syms[CHAR_BITS*int'(digit) +: CHAR_BITS];
   endfunction

endpackage

// ===== src/rit_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module rit_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rit_pkg::item_type         push_item,
   input  logic                      pop,
   output rit_pkg::item_type         pop_item,
   output rit_pkg::queue_status_type status
);

   rit_pkg::item_type                        entry_ff [rit_pkg::QUEUE_DEPTH];
   logic [rit_pkg::QUEUE_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rit_pkg::QUEUE_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rit_pkg::QUEUE_CNT_BITS-1:0]       count_ff, count_in;

   localparam logic [rit_pkg::QUEUE_PTR_BITS-1:0] PTR_LAST =
      rit_pkg::QUEUE_PTR_BITS'(rit_pkg::QUEUE_DEPTH - 1);
   localparam logic [rit_pkg::QUEUE_CNT_BITS-1:0] CNT_FULL =
      rit_pkg::QUEUE_CNT_BITS'(rit_pkg::QUEUE_DEPTH);

   always_comb begin
      status.full  = (count_ff == CNT_FULL);
      status.empty = (count_ff == '0);
      pop_item     = entry_ff[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/rit_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_front
// Input stage: holds one number, splits sign and magnitude, drops the item
// when the base is invalid, otherwise pushes it into the queue.
// ----------------------------------------------------------------------------
module rit_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rit_pkg::IN_WIDTH-1:0]  req_number,
   input  logic                          base_ok,
   input  rit_pkg::queue_status_type     status,
   output logic                          push,
   output rit_pkg::item_type             push_item
);

   logic                              hold_valid_ff, hold_valid_in;
   logic [rit_pkg::NUMBER_WIDTH-1:0]  hold_number_ff;
   logic                              done;
   logic                              accept;

   always_comb begin
      done      = hold_valid_ff && (!base_ok || !status.full);
      push      = hold_valid_ff && base_ok && !status.full;
      req_stall = hold_valid_ff && !done;
      accept    = req_valid && !req_stall;

      push_item.negative  = hold_number_ff[rit_pkg::NUMBER_WIDTH-1];
      push_item.magnitude = push_item.negative ?
         (~hold_number_ff) + {{(rit_pkg::NUMBER_WIDTH-1){1'b0}}, 1'b1} : hold_number_ff;

      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (done) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_number_ff <= req_number[rit_pkg::NUMBER_WIDTH-1:0];
      end
   end

endmodule

// ===== src/rit_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_back
// Digit engine: repeated division by the radix, eight quotient bits a cycle,
// remainders stacked and then emitted most significant first, '-' ahead of negatives.
// ----------------------------------------------------------------------------
module rit_back (
   input  logic                           clock,
   input  logic                           reset,
   input  rit_pkg::cfg_type               cfg,
   input  rit_pkg::queue_status_type      status,
   output logic                           pop,
   input  rit_pkg::item_type              pop_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rit_pkg::CHAR_BITS-1:0]  rsp_character,
   output logic                           rsp_last
);

   rit_pkg::back_state_type               state_ff, state_in;
   logic [rit_pkg::DIV_WIDTH-1:0]         div_ff, div_in;
   logic [rit_pkg::DIGIT_BITS-1:0]        rem_ff, rem_in;
   logic [rit_pkg::DIV_CNT_BITS-1:0]      cycle_ff, cycle_in;
   logic                                  negative_ff, negative_in;
   logic [rit_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   logic [rit_pkg::DIGIT_BITS-1:0]        stack_ff [rit_pkg::DIGIT_SLOTS];
   logic [rit_pkg::DIGIT_BITS-1:0]        stack_in [rit_pkg::DIGIT_SLOTS];
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [rit_pkg::CHAR_BITS-1:0]         rsp_character_ff, rsp_character_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic [rit_pkg::DIGIT_BITS:0]          radix_ext;
   logic [rit_pkg::DIGIT_BITS:0]          partial;
   logic [rit_pkg::DIGIT_BITS-1:0]        rem_step;
   logic [rit_pkg::DIV_WIDTH-1:0]         div_step;
   logic                                  out_free;
   logic                                  load;

   localparam logic [rit_pkg::DIV_CNT_BITS-1:0] CYCLE_LAST =
      rit_pkg::DIV_CNT_BITS'(rit_pkg::DIV_CYCLES - 1);
   localparam logic [rit_pkg::COUNT_BITS-1:0] COUNT_LAST =
      rit_pkg::COUNT_BITS'(rit_pkg::DIGIT_SLOTS - 1);
   localparam logic [rit_pkg::COUNT_BITS-1:0] COUNT_ONE =
      rit_pkg::COUNT_BITS'(1);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // restoring division, STEPS_PER_CYCLE quotient bits per cycle
   always_comb begin
      radix_ext = cfg.radix[rit_pkg::DIGIT_BITS:0];
      rem_step  = rem_ff;
      div_step  = div_ff;
      partial   = '0;
      for (int s = 0; s < rit_pkg::STEPS_PER_CYCLE; s++) begin
         partial  = {rem_step, div_step[rit_pkg::DIV_WIDTH-1]};
         div_step = {div_step[rit_pkg::DIV_WIDTH-2:0], 1'b0};
         if (partial >= radix_ext) begin
            partial     = partial - radix_ext;
            div_step[0] = 1'b1;
         end
         rem_step = partial[rit_pkg::DIGIT_BITS-1:0];
      end
   end

   always_comb begin
      state_in         = state_ff;
      div_in           = div_ff;
      rem_in           = rem_ff;
      cycle_in         = cycle_ff;
      negative_in      = negative_ff;
      count_in         = count_ff;
      stack_in         = stack_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      pop              = 1'b0;
      load             = 1'b0;
      out_free         = !rsp_valid_ff || !rsp_stall;

      unique case (state_ff)
         rit_pkg::BACK_IDLE: begin
            if (!status.empty) begin
               pop         = 1'b1;
               div_in      = rit_pkg::DIV_WIDTH'(pop_item.magnitude);
               rem_in      = '0;
               cycle_in    = '0;
               negative_in = pop_item.negative;
               count_in    = '0;
               state_in    = rit_pkg::BACK_DIVIDE;
            end
         end
         rit_pkg::BACK_DIVIDE: begin
            div_in   = div_step;
            rem_in   = rem_step;
            cycle_in = cycle_ff + 1'b1;
            if (cycle_ff == CYCLE_LAST) begin
               cycle_in    = '0;
               rem_in      = '0;
               count_in    = count_ff + 1'b1;
               stack_in[0] = rem_step;
               for (int i = 1; i < rit_pkg::DIGIT_SLOTS; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               if (div_step == '0 || count_ff == COUNT_LAST) begin
                  state_in = negative_ff ? rit_pkg::BACK_SIGN : rit_pkg::BACK_EMIT;
               end
            end
         end
         rit_pkg::BACK_SIGN: begin
            if (out_free) begin
               load             = 1'b1;
               rsp_character_in = rit_pkg::SIGN_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = rit_pkg::BACK_EMIT;
            end
         end
         rit_pkg::BACK_EMIT: begin
            if (out_free) begin
               load             = 1'b1;
               rsp_character_in = rit_pkg::symbol_at(stack_ff[0], cfg.symbols);
               rsp_last_in      = (count_ff == COUNT_ONE);
               count_in         = count_ff - 1'b1;
               for (int i = 0; i < rit_pkg::DIGIT_SLOTS - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               if (count_ff == COUNT_ONE) begin
                  state_in = rit_pkg::BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = rit_pkg::BACK_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rit_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         cycle_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cycle_ff     <= cycle_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff           <= div_in;
      rem_ff           <= rem_in;
      negative_ff      <= negative_in;
      stack_ff         <= stack_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

endmodule

// ===== src/radix_integer_to_text.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_text
// Converts a signed integer to its text in a configured radix, one character
// per transfer, most significant digit first, '-' ahead of negatives.
// ----------------------------------------------------------------------------
//
//   channel  ports                                    direction
//   req      req_valid req_stall req_number           in
//   rsp      rsp_valid rsp_stall rsp_character rsp_last  out
//   csr      csr_write csr_index csr_data             in
//
// Each digit is worked out in the shared divider (8 quotient bits per cycle).
// The longest item is 32 digits plus the sign (radix 2, most negative value).
// Reset clears the base registers, so the base is invalid and items are dropped.
// The two-entry queue lets the input stage take a transfer while the back is busy.
// rsp_stall only holds the output register; digit work waits for it at emission.
module radix_integer_to_text (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rit_pkg::IN_WIDTH-1:0]       req_number,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rit_pkg::CHAR_BITS-1:0]      rsp_character,
   output logic                               rsp_last,
   input  logic                               csr_write,
   input  logic [rit_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rit_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic [rit_pkg::RADIX_BITS-1:0]     base_length_ff, base_length_in;
   logic [rit_pkg::CSR_DATA_BITS-1:0]  symbols_low_ff, symbols_low_in;
   logic [rit_pkg::CSR_DATA_BITS-1:0]  symbols_high_ff, symbols_high_in;
   logic                               base_ok_ff, base_ok_in;

   rit_pkg::cfg_type                   cfg;
   rit_pkg::queue_status_type          status;
   rit_pkg::item_type                  push_item;
   rit_pkg::item_type                  pop_item;
   logic                               push;
   logic                               pop;

   always_comb begin
      base_length_in  = base_length_ff;
      symbols_low_in  = symbols_low_ff;
      symbols_high_in = symbols_high_ff;
      if (csr_write) begin
         unique case (rit_pkg::csr_index_type'(csr_index))
            rit_pkg::CSR_BASE_LENGTH:  base_length_in  = csr_data[rit_pkg::RADIX_BITS-1:0];
            rit_pkg::CSR_SYMBOLS_LOW:  symbols_low_in  = csr_data;
            rit_pkg::CSR_SYMBOLS_HIGH: symbols_high_in = csr_data;
            default: ;
         endcase
      end
      base_ok_in  = rit_pkg::base_valid(base_length_ff, {symbols_high_ff, symbols_low_ff});
      cfg.base_ok = base_ok_ff;
      cfg.radix   = base_length_ff;
      cfg.symbols = {symbols_high_ff, symbols_low_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff  <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
         base_ok_ff      <= 1'b0;
      end else begin
         base_length_ff  <= base_length_in;
         symbols_low_ff  <= symbols_low_in;
         symbols_high_ff <= symbols_high_in;
         base_ok_ff      <= base_ok_in;
      end
   end

   rit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .base_ok    (cfg.base_ok),
      .status     (status),
      .push       (push),
      .push_item  (push_item)
   );

   rit_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (status)
   );

   rit_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .status        (status),
      .pop           (pop),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== src/rit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rit_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [rit_pkg::CHAR_BITS-1:0] rsp_character,
   input  logic                          rsp_last
);

   // a stalled transfer holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_character) && $stable(rsp_last))

   // no result right after reset
   `ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid)

   // valid bases never hold a zero byte, so no zero character goes out
   `ASSERT_SAME(a_rsp_nonzero, clock, reset, rsp_valid, rsp_character != '0)

   // the minus sign is always followed by at least one digit
   `ASSERT_SAME(a_sign_not_last, clock, reset, rsp_valid && rsp_character == rit_pkg::SIGN_MINUS, !rsp_last)

endmodule

bind radix_integer_to_text rit_checker u_rit_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);
